### hw/rtl/chol_pkg.sv
// ----------------------------------------------------------------------------
// chol_pkg
// shared constants and a saturation helper for the cholesky factorization block
// ----------------------------------------------------------------------------
package chol_pkg;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned FRAC_W = 16;
    localparam int unsigned SIZE_W = 4;

    localparam logic signed [DATA_W-1:0] SAT_MAX = 32'sh7fff_ffff;
    localparam logic signed [DATA_W-1:0] SAT_MIN = 32'sh8000_0000;

    // saturate a wide signed value into the 32-bit q16.16 range
    function automatic logic signed [DATA_W-1:0] sat_q16(input logic signed [63:0] x);
        logic signed [DATA_W-1:0] res;
        if (x > 64'sd2147483647) begin
            res = SAT_MAX;
        end else if (x < -64'sd2147483648) begin
            res = SAT_MIN;
        end else begin
            res = x[DATA_W-1:0];
        end
        return res;
    endfunction

endpackage

### hw/rtl/chol_sqrt.sv
// ----------------------------------------------------------------------------
// chol_sqrt
// bit-serial integer square root, floor(sqrt(x)), one result bit per cycle
// ----------------------------------------------------------------------------
module chol_sqrt
    import chol_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [47:0] i_radicand,
    output logic        o_done,
    output logic [23:0] o_root
);

    logic [47:0] r_rem;
    logic [47:0] r_x;
    logic [23:0] r_root;
    logic [4:0]  r_cnt;
    logic        r_busy;
    logic        r_done;

    logic [49:0] w_trial;
    logic [49:0] w_rem_sh;

    always_comb begin
        w_rem_sh = {r_rem, r_x[47:46]};
        w_trial  = {24'd0, r_root, 2'b01};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'd23;
                r_rem  <= '0;
                r_x    <= i_radicand;
                r_root <= '0;
            end else if (r_busy) begin
                r_x <= {r_x[45:0], 2'b00};
                if (w_rem_sh >= w_trial) begin
                    r_rem  <= 48'(w_rem_sh - w_trial);
                    r_root <= {r_root[22:0], 1'b1};
                end else begin
                    r_rem  <= w_rem_sh[47:0];
                    r_root <= {r_root[22:0], 1'b0};
                end
                if (r_cnt == 5'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 5'd1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

### hw/rtl/chol_div.sv
// ----------------------------------------------------------------------------
// chol_div
// restoring divider, (num * 2^16) / den truncated toward zero, saturated
// ----------------------------------------------------------------------------
module chol_div
    import chol_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic signed [DATA_W-1:0] i_num,
    input  logic [23:0]              i_den,
    output logic                     o_done,
    output logic signed [DATA_W-1:0] o_quot
);

    // dividend magnitude is at most 2^47, held in 48 bits
    logic [47:0] r_dvd;
    logic [24:0] r_rem;
    logic [47:0] r_q;
    logic [23:0] r_den;
    logic        r_neg;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic        r_done;

    logic [31:0] w_mag;
    logic [24:0] w_sh;
    logic signed [63:0] w_signed;

    assign w_mag = i_num[DATA_W-1] ? 32'(-i_num) : 32'(i_num);
    assign w_sh  = {r_rem[23:0], r_dvd[47]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd47;
                r_dvd  <= {w_mag, 16'd0};
                r_rem  <= '0;
                r_q    <= '0;
                r_den  <= i_den;
                r_neg  <= i_num[DATA_W-1];
            end else if (r_busy) begin
                r_dvd <= {r_dvd[46:0], 1'b0};
                if (w_sh >= {1'b0, r_den}) begin
                    r_rem <= w_sh - {1'b0, r_den};
                    r_q   <= {r_q[46:0], 1'b1};
                end else begin
                    r_rem <= w_sh;
                    r_q   <= {r_q[46:0], 1'b0};
                end
                if (r_cnt == 6'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 6'd1;
                end
            end
        end
    end

    assign w_signed = r_neg ? -$signed({16'd0, r_q}) : $signed({16'd0, r_q});
    assign o_quot   = sat_q16(w_signed);
    assign o_done   = r_done;

endmodule

### hw/rtl/cholesky_factorization.sv
// ----------------------------------------------------------------------------
// cholesky_factorization
// streamed cholesky factor of a symmetric positive-definite q16.16 matrix
// ----------------------------------------------------------------------------
// Load n*n elements in order row + column*n, one per cycle while s_axis_tready
// is high. After the last one the block factors the matrix in place in a
// MAX_N*MAX_N-entry memory with a registered read. It then streams all n*n
// elements of G, with tlast on the final one and tuser set if any pivot was
// not positive. For each entry of column j at or below the pivot, computing
// takes an entry read, then two memory reads, a registered multiply and an
// accumulate per inner product term. It then takes a square root of the
// pivot, one division for each entry at or below the pivot, and clears the
// part above it. A column whose pivot is not positive skips the square root
// and the divisions and clears one entry a cycle. No input is taken while
// computing or sending.
// ----------------------------------------------------------------------------
module cholesky_factorization
    import chol_pkg::*;
#(
    parameter int unsigned MAX_N = 8
)
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_data,     // [3:0] matrix_size
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] elem_value
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] out_value
    output logic        m_axis_tlast,
    output logic        m_axis_tuser    // [0] not_positive_definite
);

    localparam int unsigned DEPTH = MAX_N * MAX_N;
    localparam int unsigned AW    = $clog2(DEPTH);
    localparam int unsigned IW    = $clog2(MAX_N);
    localparam int unsigned CW    = $clog2(DEPTH + 1);

    localparam logic [3:0] ST_LOAD  = 4'd0;
    localparam logic [3:0] ST_ACC0  = 4'd1;  // read a(i,j)
    localparam logic [3:0] ST_RDJ   = 4'd2;  // read g(j,k)
    localparam logic [3:0] ST_RDI   = 4'd3;  // read g(i,k)
    localparam logic [3:0] ST_MUL   = 4'd4;  // registered product of the two operands
    localparam logic [3:0] ST_WCOL  = 4'd5;  // saturate into work column
    localparam logic [3:0] ST_SQRT  = 4'd6;
    localparam logic [3:0] ST_DIV   = 4'd7;
    localparam logic [3:0] ST_DIVW  = 4'd8;
    localparam logic [3:0] ST_ZERO  = 4'd9;  // clear upper part of column
    localparam logic [3:0] ST_OUTRD = 4'd10;
    localparam logic [3:0] ST_OUT   = 4'd11;
    localparam logic [3:0] ST_TAKE  = 4'd12;

    logic [3:0]        r_state;
    logic [SIZE_W-1:0] r_size;
    logic [CW-1:0]     r_cnt;
    logic              r_fail;
    logic [IW:0]       r_i, r_j, r_k;
    logic signed [63:0] r_acc;
    logic signed [DATA_W-1:0] r_opj;
    logic signed [63:0] r_prod;
    logic signed [DATA_W-1:0] r_wcol [MAX_N];
    logic [23:0]       r_root;
    logic [31:0]       r_odata;
    logic              r_ovalid, r_olast;

    logic signed [DATA_W-1:0] r_mem [DEPTH];
    logic signed [DATA_W-1:0] r_rdata;

    logic [IW:0]  w_n;
    logic [CW-1:0] w_total;
    logic          w_mem_we;
    logic [AW-1:0] w_mem_wa, w_mem_ra;
    logic signed [DATA_W-1:0] w_mem_wd;
    logic          w_sq_start, w_sq_done, w_dv_start, w_dv_done;
    logic [23:0]   w_sq_root;
    logic signed [DATA_W-1:0] w_dv_q;
    logic signed [DATA_W-1:0] w_piv;
    logic          w_in_xfer, w_out_xfer;

    always_comb begin
        if (r_size == '0) begin
            w_n = (IW+1)'(1);
        end else if ({1'b0, r_size} > 5'(MAX_N)) begin
            w_n = (IW+1)'(MAX_N);
        end else begin
            w_n = (IW+1)'(r_size);
        end
        w_total = CW'(w_n) * CW'(w_n);
    end

    function automatic logic [AW-1:0] f_addr(input logic [IW:0] row, input logic [IW:0] col,
                                             input logic [IW:0] n);
        return AW'(32'(row) + 32'(col) * 32'(n));
    endfunction

    assign w_in_xfer  = s_axis_tvalid && s_axis_tready;
    assign w_out_xfer = m_axis_tvalid && m_axis_tready;
    assign w_piv      = r_wcol[r_j[IW-1:0]];

    // memory port control
    always_comb begin
        w_mem_we = 1'b0;
        w_mem_wa = f_addr(r_i, r_j, w_n);
        w_mem_wd = w_dv_q;
        w_mem_ra = f_addr(r_i, r_j, w_n);
        unique case (r_state)
            ST_LOAD: begin
                w_mem_we = w_in_xfer;
                w_mem_wa = AW'(r_cnt);
                w_mem_wd = s_axis_tdata;
            end
            ST_ACC0: w_mem_ra = f_addr(r_i, r_j, w_n);
            ST_RDJ:  w_mem_ra = f_addr(r_j, r_k, w_n);
            ST_RDI:  w_mem_ra = f_addr(r_i, r_k, w_n);
            ST_DIVW: begin
                w_mem_we = 1'b1;
                w_mem_wd = r_fail && (w_piv <= 0) ? '0 : w_dv_q;
            end
            ST_ZERO: begin
                // only rows above the pivot, the diagonal keeps its factor
                w_mem_we = (r_i < r_j);
                w_mem_wa = f_addr(r_i, r_j, w_n);
                w_mem_wd = '0;
            end
            ST_OUTRD, ST_OUT, ST_TAKE: w_mem_ra = AW'(r_cnt);
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[w_mem_wa] <= w_mem_wd;
        end
        r_rdata <= r_mem[w_mem_ra];
    end

    logic signed [DATA_W-1:0] r_dnum;
    logic r_piv_bad;
    logic signed [DATA_W-1:0] w_piv_next;

    assign w_piv_next = (r_i == r_j) ? sat_q16(r_acc) : w_piv;
    assign w_sq_start = (r_state == ST_WCOL) && (r_i == w_n - 1'b1) && !(w_piv_next <= 0);
    assign w_dv_start = (r_state == ST_DIV);

    chol_sqrt u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_sq_start),
        .i_radicand ({w_piv_next[31:0], 16'd0}),
        .o_done     (w_sq_done),
        .o_root     (w_sq_root)
    );

    chol_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_dv_start),
        .i_num   (r_dnum),
        .i_den   (r_root),
        .o_done  (w_dv_done),
        .o_quot  (w_dv_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_LOAD;
            r_size   <= SIZE_W'(8);
            r_cnt    <= '0;
            r_fail   <= 1'b0;
            r_ovalid <= 1'b0;
            r_i      <= '0;
            r_j      <= '0;
            r_k      <= '0;
            r_piv_bad <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_size <= i_cfg_data[SIZE_W-1:0];
                r_cnt  <= '0;
                r_fail <= 1'b0;
                r_state <= ST_LOAD;
            end else begin
                unique case (r_state)
                    ST_LOAD: begin
                        if (w_in_xfer) begin
                            if (r_cnt + 1'b1 >= w_total) begin
                                r_cnt   <= '0;
                                r_j     <= '0;
                                r_i     <= '0;
                                r_k     <= '0;
                                r_state <= ST_ACC0;
                            end else begin
                                r_cnt <= r_cnt + 1'b1;
                            end
                        end
                    end
                    ST_ACC0: begin
                        r_k     <= '0;
                        r_state <= ST_RDJ;
                    end
                    ST_RDJ: begin
                        if (r_k == '0) begin
                            r_acc <= 64'(r_rdata);
                        end
                        if (r_k == r_j) begin
                            r_state <= ST_WCOL;
                        end else begin
                            r_state <= ST_RDI;
                        end
                    end
                    ST_RDI: begin
                        r_opj   <= r_rdata;
                        r_state <= ST_MUL;
                    end
                    ST_MUL: begin
                        r_prod  <= 64'(r_opj) * 64'(r_rdata);
                        r_k     <= r_k + 1'b1;
                        r_state <= ST_TAKE;
                    end
                    ST_TAKE: begin
                        r_acc   <= r_acc - (r_prod >>> FRAC_W);
                        r_state <= ST_RDJ;
                    end
                    ST_WCOL: begin
                        r_wcol[r_i[IW-1:0]] <= sat_q16(r_acc);
                        if (r_i == w_n - 1'b1) begin
                            r_i <= r_j;
                            if (w_piv_next <= 0) begin
                                r_fail    <= 1'b1;
                                r_piv_bad <= 1'b1;
                                r_state   <= ST_DIVW;
                            end else begin
                                r_piv_bad <= 1'b0;
                                r_state   <= ST_SQRT;
                            end
                        end else begin
                            r_i     <= r_i + 1'b1;
                            r_state <= ST_ACC0;
                        end
                    end
                    ST_SQRT: begin
                        if (w_sq_done) begin
                            r_root  <= w_sq_root;
                            r_dnum  <= r_wcol[r_i[IW-1:0]];
                            r_state <= ST_DIV;
                        end
                    end
                    ST_DIV: r_state <= ST_DIVW;
                    ST_DIVW: begin
                        if (r_piv_bad || w_dv_done) begin
                            if (r_i == w_n - 1'b1) begin
                                r_i     <= '0;
                                r_state <= ST_ZERO;
                            end else begin
                                r_i <= r_i + 1'b1;
                                if (!r_piv_bad) begin
                                    r_dnum  <= r_wcol[IW'(r_i + 1'b1)];
                                    r_state <= ST_DIV;
                                end
                            end
                        end
                    end
                    ST_ZERO: begin
                        if (r_i >= r_j) begin
                            if (r_j == w_n - 1'b1) begin
                                r_cnt   <= '0;
                                r_state <= ST_OUTRD;
                            end else begin
                                r_j     <= r_j + 1'b1;
                                r_i     <= r_j + 1'b1;
                                r_state <= ST_ACC0;
                            end
                        end else begin
                            r_i <= r_i + 1'b1;
                        end
                    end
                    ST_OUTRD: r_state <= ST_OUT;
                    ST_OUT: begin
                        if (!r_ovalid || w_out_xfer) begin
                            r_ovalid <= 1'b1;
                            r_odata  <= r_rdata;
                            r_olast  <= (r_cnt + 1'b1 == w_total);
                            if (r_cnt + 1'b1 == w_total) begin
                                r_state <= ST_LOAD;
                                r_cnt   <= '0;
                            end else begin
                                r_cnt   <= r_cnt + 1'b1;
                                r_state <= ST_OUTRD;
                            end
                        end
                    end
                    default: r_state <= ST_LOAD;
                endcase
                if (w_out_xfer && !(r_state == ST_OUT)) begin
                    r_ovalid <= 1'b0;
                end
                if (w_out_xfer && r_olast) begin
                    r_fail <= 1'b0;
                end
            end
        end
    end

    // fail flag is held in an output register so a new load may begin
    logic r_ouser;
    always_ff @(posedge i_clk) begin
        if (r_state == ST_OUT && (!r_ovalid || w_out_xfer)) begin
            r_ouser <= r_fail;
        end
    end

    assign s_axis_tready = (r_state == ST_LOAD) && !(r_ovalid && r_olast);
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tlast  = r_olast;
    assign m_axis_tuser  = r_ouser;

`ifndef SYNTHESIS
    a_no_load_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_LOAD) |-> !s_axis_tready) else $error("load while busy");
    a_out_only_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> ($past(r_state) == ST_OUT)) else $error("stray output");
    a_sqrt_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sq_done |-> (r_state == ST_SQRT)) else $error("sqrt done out of place");
    a_div_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_dv_done |-> (r_state == ST_DIVW)) else $error("div done out of place");
`endif

endmodule

### sim/tb_cholesky_factorization.sv
// ----------------------------------------------------------------------------
// tb_cholesky_factorization
// streams matrices into the cholesky block, predicts each factor in fixed
// point and compares every output transfer with the predicted element
// ----------------------------------------------------------------------------
module tb_cholesky_factorization;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_N = 8;
    localparam int IDLE_LIMIT = 200000;

    typedef struct packed {
        logic [31:0] value;
        logic        last;
        logic        npd;
    } t_factor_elem;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [7:0]  i_cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic        m_axis_tuser;

    cholesky_factorization #(.MAX_N(MAX_N)) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // predictor state
    longint      mat[MAX_N*MAX_N];
    longint      col_acc[MAX_N];
    int          load_count;
    logic [3:0]  size_reg;

    logic [31:0]  elem_queue[$];
    t_factor_elem factor_queue[$];
    int  errors;
    int  idle_cycles;
    int  in_gap;
    int  out_gap;

    function automatic int eff_n();
        int n;
        n = size_reg;
        if (n == 0) n = 1;
        if (n > MAX_N) n = MAX_N;
        return n;
    endfunction

    function automatic longint sat32(longint x);
        if (x > 64'sd2147483647) return 64'sd2147483647;
        if (x < -64'sd2147483648) return -64'sd2147483648;
        return x;
    endfunction

    function automatic longint isqrt64(longint unsigned x);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return longint'(r);
    endfunction

    // mostly no gap or a short one, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 31);
        if (r == 0) return $urandom_range(20, 80);
        if (r < 16) return 0;
        return $urandom_range(1, 3);
    endfunction

    // accept one element; on the last one factor and queue all n*n outputs
    task automatic load_element(logic [31:0] v);
        int n, tot, i, j, k;
        longint acc, s, p;
        bit fail;
        n = eff_n();
        tot = n * n;
        if (load_count >= tot) load_count = 0;
        mat[load_count] = longint'(signed'(v));
        load_count++;
        if (load_count < tot) return;
        fail = 0;
        for (j = 0; j < n; j++) begin
            for (i = j; i < n; i++) begin
                acc = mat[i + j*n];
                for (k = 0; k < j; k++) begin
                    p = mat[j + k*n] * mat[i + k*n];
                    acc -= (p >>> 16);
                end
                col_acc[i] = sat32(acc);
            end
            if (col_acc[j] <= 0) begin
                fail = 1;
                for (i = j; i < n; i++) mat[i + j*n] = 0;
            end else begin
                s = isqrt64(longint'(col_acc[j]) * 65536);
                for (i = j; i < n; i++) mat[i + j*n] = sat32((col_acc[i] * 65536) / s);
            end
            for (i = 0; i < j; i++) mat[i + j*n] = 0;
        end
        for (k = 0; k < tot; k++)
            factor_queue.push_back('{mat[k][31:0], k + 1 == tot, fail});
        load_count = 0;
    endtask

    function automatic logic [31:0] rand_elem();
        case ($urandom_range(0, 5))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            default: return $urandom();
        endcase
    endfunction

    // symmetric matrix with a heavy diagonal, mostly positive definite; fill column order
    task automatic queue_matrix(int n, bit noisy);
        int i, j;
        int a[MAX_N][MAX_N];
        for (j = 0; j < n; j++)
            for (i = j; i < n; i++) begin
                if (i == j) a[i][j] = $urandom_range(1 << 16, 40 << 16);
                else a[i][j] = $urandom_range(0, 8 << 16) - (4 << 16);
                a[j][i] = a[i][j];
            end
        for (j = 0; j < n; j++)
            for (i = 0; i < n; i++)
                elem_queue.push_back(noisy ? rand_elem() : a[i][j]);
    endtask

    task automatic write_size(logic [3:0] sz);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= {4'b0, sz};
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        size_reg  = sz;
        load_count = 0;
    endtask

    // sample after the edge settles so the last transfer is already predicted
    task automatic drain_all();
        do begin
            @(posedge i_clk);
            #1;
        end while (elem_queue.size() != 0 || s_axis_tvalid);
        wait (factor_queue.size() == 0);
        repeat (50) @(posedge i_clk);
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            in_gap        <= 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) load_element(s_axis_tdata);
            if (in_gap > 0) begin
                in_gap <= in_gap - 1;
                if (s_axis_tvalid && s_axis_tready) s_axis_tvalid <= 1'b0;
            end else if ((!s_axis_tvalid || s_axis_tready) && elem_queue.size() > 0) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= elem_queue.pop_front();
                in_gap        <= pick_gap();
            end else if (s_axis_tvalid && s_axis_tready) begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // monitor and output stall
    always @(posedge i_clk) begin
        t_factor_elem got, want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            idle_cycles   <= 0;
            out_gap       <= 0;
        end else begin
            if (out_gap > 0) begin
                m_axis_tready <= 1'b0;
                out_gap       <= out_gap - 1;
            end else begin
                m_axis_tready <= 1'b1;
                out_gap       <= pick_gap();
            end
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (i_cfg_valid && o_cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (m_axis_tvalid && m_axis_tready) begin
                got = '{m_axis_tdata, m_axis_tlast, m_axis_tuser};
                if (factor_queue.size() == 0) begin
                    $display("%0t unexpected output: expected none, actual %h", $time, got);
                    errors++;
                end else begin
                    want = factor_queue.pop_front();
                    if (got !== want) begin
                        $display({"%0t mismatch: expected value %h last %b npd %b,",
                                  " actual value %h last %b npd %b"},
                                 $time, want.value, want.last, want.npd,
                                 got.value, got.last, got.npd);
                        errors++;
                    end
                end
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("FAIL cholesky_factorization");
                $finish;
            end
        end
    end

    initial begin
        int m, n;
        errors = 0;
        load_count = 0;
        size_reg = 4'd8;
        i_rst_n = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: 1x1 extremes, zero and negative pivot, size 0 and above max
        write_size(4'd1);
        elem_queue = '{32'h7fff_ffff, 32'h8000_0000, 32'h0000_0000, 32'h0000_0001,
                       32'h0001_0000, 32'hffff_ffff};
        drain_all();
        write_size(4'd0);
        elem_queue = '{32'h0004_0000};
        drain_all();
        write_size(4'd2);
        elem_queue = '{32'h0000_0000, 32'h0001_0000, 32'hdead_beef, 32'h0004_0000,
                       32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff};
        drain_all();
        // partial load discarded by a size write
        elem_queue = '{32'h5555_aaaa};
        drain_all();
        write_size(4'd15);
        queue_matrix(8, 0);
        drain_all();

        // a few random small matrices
        for (m = 0; m < 3; m++) begin
            n = $urandom_range(1, 4);
            write_size(n[3:0]);
            queue_matrix(n, $urandom_range(0, 3) == 0);
            drain_all();
        end

        if (errors == 0) begin
            $display("PASS cholesky_factorization");
        end else begin
            $display("FAIL cholesky_factorization");
        end
        $finish;
    end
endmodule

### sim.f
hw/rtl/chol_pkg.sv
hw/rtl/chol_sqrt.sv
hw/rtl/chol_div.sv
hw/rtl/cholesky_factorization.sv
sim/tb_cholesky_factorization.sv
